/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted
`define TLAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset
`define TLAS_NEVER(label, expr, msg) \
  `TLAS_ASSERT(label, !(expr), msg)

`endif

/* hw/rtl/tlas_pkg.sv */
// Constants, tables and helpers of the two-link arm servo solver
package tlas_pkg;

  localparam int ANGLE_STEPS       = 180;
  localparam int COS_FRACTION_BITS = 14;
  localparam int Q_ONE             = 1 << COS_FRACTION_BITS;

  localparam int X_W     = 13;
  localparam int S_W     = 2 * X_W;
  localparam int LEN_W   = X_W;
  localparam int LINK_W  = 8;
  localparam int LK_W    = LINK_W + 4;
  localparam int NUM_W   = S_W + 2;
  localparam int DEN_W   = LK_W + LEN_W + 1;
  localparam int OUT_W   = 12;
  localparam int COS_W   = COS_FRACTION_BITS + 2;
  localparam int ANG_W   = $clog2(ANGLE_STEPS + 1);
  localparam int ROM_AW  = $clog2(ANGLE_STEPS);
  localparam int K_W     = ANG_W + 3;
  localparam int CFG_IDX_W = 2;

  localparam int SQRT_STEPS   = X_W;
  localparam int DIV_STEPS    = COS_FRACTION_BITS + 1;
  localparam int SEARCH_STEPS = $clog2(ANGLE_STEPS) + 1;
  localparam int LANE_LAT     = DIV_STEPS + SEARCH_STEPS + 2;

  // pipeline stage numbers, counted from the accept edge
  localparam int ST_SQ0 = 3;
  localparam int ST_PM  = ST_SQ0 + SQRT_STEPS;
  localparam int ST_PN  = ST_PM + 1;
  localparam int ST_OUT = ST_PN + LANE_LAT + 1;

  localparam logic [OUT_W-1:0] PULSE_BASE = OUT_W'(500);
  localparam logic [OUT_W-1:0] PULSE_TOP  = OUT_W'(2500);
  localparam int QUARTER_TURN = 90;
  localparam int HALF_TURN    = 180;

  localparam logic [LINK_W-1:0] UPPER_RST = LINK_W'(105);
  localparam logic [LINK_W-1:0] FORE_RST  = LINK_W'(97);
  localparam logic [LINK_W-1:0] LOWER_RST = LINK_W'(160);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER = 2'd0,
    REG_FORE  = 2'd1,
    REG_LOWER = 2'd2
  } cfg_reg_t;

  localparam int COS_E5 [91] = '{
    100000,
    99985,99939,99863,99756,99619,99452,99255,99027,98769,98481,
    98163,97815,97437,97030,96593,96126,95630,95106,94552,93969,
    93358,92718,92050,91355,90631,89879,89101,88295,87462,86603,
    85717,84805,83867,82904,81915,80902,79864,78801,77715,76604,
    75471,74314,73135,71934,70711,69466,68200,66913,65606,64279,
    62932,61566,60182,58779,57358,55919,54464,52992,51504,50000,
    48481,46947,45399,43837,42262,40674,39073,37461,35837,34202,
    32557,30902,29237,27564,25882,24192,22495,20791,19081,17365,
    15643,13917,12187,10453,8716,6976,5234,3490,1745,0
  };

  typedef logic signed [COS_W-1:0] cos_rom_t [ANGLE_STEPS];
  typedef logic [OUT_W-1:0] pwm_rom_t [ANGLE_STEPS];

  // entry i holds cos(i+1 degrees) in Q1.COS_FRACTION_BITS
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t t;
    int d;
    longint mag;
    longint q;
    bit neg;
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      d = (i + 1) % 360;
      neg = 1'b0;
      if (d <= 90) begin
        mag = COS_E5[d];
      end else if (d <= 180) begin
        mag = COS_E5[180 - d];
        neg = 1'b1;
      end else if (d <= 270) begin
        mag = COS_E5[d - 180];
        neg = 1'b1;
      end else begin
        mag = COS_E5[360 - d];
      end
      q = (mag * Q_ONE + 50000) / 100000;
      t[i] = neg ? COS_W'(-q) : COS_W'(q);
    end
    return t;
  endfunction

  function automatic pwm_rom_t build_pwm_rom();
    pwm_rom_t t;
    int p;
    for (int k = 0; k < ANGLE_STEPS; k++) begin
      p = 500 + ((k + 1) * 1111) / 100;
      if (p > 2500) begin
        p = 2500;
      end
      t[k] = OUT_W'(p);
    end
    return t;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();
  localparam pwm_rom_t PWM_ROM = build_pwm_rom();

  // clamp an angle index to the table and look up its pulse; msb is the clamp flag
  function automatic logic [OUT_W:0] pulse_map(logic signed [K_W-1:0] k);
    logic [ROM_AW-1:0] idx;
    logic flg;
    flg = 1'b0;
    if (k < 0) begin
      idx = '0;
      flg = 1'b1;
    end else if (k > K_W'(ANGLE_STEPS - 1)) begin
      idx = ROM_AW'(ANGLE_STEPS - 1);
      flg = 1'b1;
    end else begin
      idx = k[ROM_AW-1:0];
    end
    return {flg, PWM_ROM[idx]};
  endfunction

endpackage

/* hw/rtl/tlas_cos_lane.sv */
// Cosine lane: pipelined num/den ratio in Q format, then pipelined table search for the angle
module tlas_cos_lane (
  input  logic                                clk,
  input  logic signed [tlas_pkg::NUM_W-1:0]   num,
  input  logic        [tlas_pkg::DEN_W-1:0]   den,
  output logic        [tlas_pkg::ANG_W-1:0]   ang,
  output logic                                flag
);

  localparam int NW = tlas_pkg::NUM_W;
  localparam int DW = tlas_pkg::DEN_W;
  localparam int DS = tlas_pkg::DIV_STEPS;
  localparam int SS = tlas_pkg::SEARCH_STEPS;
  localparam int AW = tlas_pkg::ANG_W;
  localparam int CW = tlas_pkg::COS_W;

  logic [NW-1:0] mag;
  logic          big;

  logic [DW:0]   rem_r [DS];
  logic [DW-1:0] den_r [DS];
  logic [DS-1:0] quo_r [DS+1];
  logic [DS:0]   sat_r;
  logic [DS:0]   dz_r;
  logic [DS:0]   neg_r;

  logic [DS-1:0] qmag;
  logic          over;
  logic [CW-1:0] cmag;
  logic [CW-1:0] cval;

  logic signed [CW-1:0] sc_r [SS];
  logic [SS:0]          sf_r;
  logic [AW-1:0]        lo_r [1:SS];
  logic [AW-1:0]        hi_r [1:SS];
  logic [SS:1]          dn_r;

  // prep: magnitude, early saturation when |num| >= 2*den
  always_comb begin
    mag = num[NW-1] ? $unsigned(-num) : $unsigned(num);
    big = {1'b0, mag} >= (NW + 1)'({den, 1'b0});
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= big ? '0 : mag[DW:0];
    den_r[0] <= den;
    quo_r[0] <= '0;
    sat_r[0] <= big;
    dz_r[0]  <= (den == '0);
    neg_r[0] <= num[NW-1];
    sat_r[DS:1] <= sat_r[DS-1:0];
    dz_r[DS:1]  <= dz_r[DS-1:0];
    neg_r[DS:1] <= neg_r[DS-1:0];
  end

  // restoring division, one quotient bit per stage
  for (genvar g = 0; g < DS; g++) begin : g_div
    logic [DW:0] sh;
    logic [DW:0] dif;
    logic        ge;
    always_comb begin
      sh  = (g == 0) ? rem_r[g] : {rem_r[g][DW-1:0], 1'b0};
      ge  = sh >= {1'b0, den_r[g]};
      dif = sh - {1'b0, den_r[g]};
    end
    always_ff @(posedge clk) begin
      quo_r[g+1] <= {quo_r[g][DS-2:0], ge};
    end
    if (g < DS - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        rem_r[g+1] <= ge ? dif : sh;
        den_r[g+1] <= den_r[g];
      end
    end
  end

  // saturate to +-1, zero denominator gives 0
  always_comb begin
    qmag = quo_r[DS];
    over = sat_r[DS] || (qmag > DS'(tlas_pkg::Q_ONE));
    cmag = over ? CW'(tlas_pkg::Q_ONE) : CW'(qmag);
    if (dz_r[DS]) begin
      cval = '0;
    end else begin
      cval = neg_r[DS] ? (-cmag) : cmag;
    end
  end

  always_ff @(posedge clk) begin
    sc_r[0] <= $signed(cval);
    sf_r[0] <= dz_r[DS] || over;
    sf_r[SS:1] <= sf_r[SS-1:0];
  end

  // binary search, one probe per stage
  for (genvar g = 0; g < SS; g++) begin : g_srch
    logic [AW-1:0]        lo;
    logic [AW-1:0]        hi;
    logic                 dn;
    logic [AW:0]          sum;
    logic [AW-1:0]        mid;
    logic signed [CW-1:0] ent;
    logic [AW-1:0]        lo_nxt;
    logic [AW-1:0]        hi_nxt;
    logic                 dn_nxt;
    if (g == 0) begin : g_init
      assign lo = AW'(1);
      assign hi = AW'(tlas_pkg::ANGLE_STEPS);
      assign dn = 1'b0;
    end else begin : g_mid
      assign lo = lo_r[g];
      assign hi = hi_r[g];
      assign dn = dn_r[g];
    end
    always_comb begin
      sum = {1'b0, lo} + {1'b0, hi};
      mid = sum[AW:1];
      ent = tlas_pkg::COS_ROM[mid[tlas_pkg::ROM_AW-1:0]];
      lo_nxt = lo;
      hi_nxt = hi;
      dn_nxt = dn;
      if (!dn && (lo < hi)) begin
        if (sc_r[g] < ent) begin
          lo_nxt = mid + AW'(1);
        end else if (sc_r[g] > ent) begin
          hi_nxt = mid - AW'(1);
        end else begin
          hi_nxt = mid;
          dn_nxt = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      lo_r[g+1] <= lo_nxt;
      hi_r[g+1] <= hi_nxt;
      dn_r[g+1] <= dn_nxt;
    end
    if (g < SS - 1) begin : g_cfwd
      always_ff @(posedge clk) begin
        sc_r[g+1] <= sc_r[g];
      end
    end
  end

  assign ang  = hi_r[SS];
  assign flag = sf_r[SS];

endmodule

/* hw/rtl/two_link_arm_servo_solver.sv */
// Top level of the two-link arm servo solver
//
// Channels: a request is taken on a rising edge with start high and busy low;
// in_x_pos and in_z_pos carry the target in 1/16 mm. busy is always low, so a
// new request may enter on every cycle. Each result shows for one cycle with
// out_valid high: three servo pulse widths in microseconds and out_clamped.
// Link lengths are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high. Write them only while no request is in flight.
// Pipeline: the 13-stage square root, the 15-stage quotient and the 9-stage ROM
// search lie between the accept edge and the rise of out_valid.
// Throughput: one request per cycle, results in request order.
// Reset (rst_n low, synchronous) clears all in-flight requests and loads the
// link registers with 105, 97 and 160 mm. The receiver cannot stall: a result
// is on the ports for exactly one cycle.
`include "assert_macros.svh"

module two_link_arm_servo_solver (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [tlas_pkg::X_W-1:0]      in_x_pos,
  input  logic signed [tlas_pkg::X_W-1:0]      in_z_pos,
  output logic                                 out_valid,
  output logic        [tlas_pkg::OUT_W-1:0]    out_servo_a_us,
  output logic        [tlas_pkg::OUT_W-1:0]    out_servo_b_us,
  output logic        [tlas_pkg::OUT_W-1:0]    out_servo_c_us,
  output logic                                 out_clamped,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [tlas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [tlas_pkg::LINK_W-1:0]   cfg_data
);

  localparam int XW  = tlas_pkg::X_W;
  localparam int SW  = tlas_pkg::S_W;
  localparam int LW  = tlas_pkg::LEN_W;
  localparam int KW  = tlas_pkg::LK_W;
  localparam int NW  = tlas_pkg::NUM_W;
  localparam int DW  = tlas_pkg::DEN_W;
  localparam int AW  = tlas_pkg::ANG_W;
  localparam int OW  = tlas_pkg::OUT_W;
  localparam int QS  = tlas_pkg::SQRT_STEPS;
  localparam int PM  = tlas_pkg::ST_PM;
  localparam int PN  = tlas_pkg::ST_PN;
  localparam int SO  = tlas_pkg::ST_OUT;
  localparam int KSW = tlas_pkg::K_W;

  logic                   in_acc;
  logic [SO:0]            vld_r;
  logic [SO-1:0]          zn_r;
  logic signed [XW-1:0]   xs_r [0:PM-1];
  logic signed [2*XW-1:0] xx_r;
  logic signed [2*XW-1:0] zz_r;
  logic [SW-1:0]          ss_r [2:PM-1];
  logic [SW-1:0]          srem_r [QS+1];
  logic [SW:0]            root_r [QS+1];

  logic [tlas_pkg::LINK_W-1:0] upper_r, fore_r, lower_r;
  logic [KW-1:0]          lu, lf, lw;
  logic [LW-1:0]          len;
  logic [2*KW-1:0]        uu_r, ff_r, ww_r, fw_r;
  logic [KW+LW-1:0]       ul_r, fl_r;
  logic [LW-1:0]          len_r;
  logic signed [XW-1:0]   xm_r;
  logic [SW-1:0]          sm_r;

  logic signed [NW-1:0]   na_r, nb_r, nc_r;
  logic [DW-1:0]          da_r, db_r, dc_r;
  logic [NW-1:0]          s_n, uu_n, ff_n, ww_n;

  logic [AW-1:0]          ang_a, ang_b, ang_c;
  logic                   fl_a, fl_b, fl_c;
  logic signed [KSW-1:0]  ka, kb, kc, ea, eb, ec;
  logic [OW:0]            pa, pb, pc;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_acc    = start && !busy;

  // link registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= tlas_pkg::UPPER_RST;
      fore_r  <= tlas_pkg::FORE_RST;
      lower_r <= tlas_pkg::LOWER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tlas_pkg::REG_UPPER: upper_r <= cfg_data;
        tlas_pkg::REG_FORE:  fore_r  <= cfg_data;
        tlas_pkg::REG_LOWER: lower_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SO-1:0], in_acc};
    end
  end

  always_ff @(posedge clk) begin
    zn_r <= {zn_r[SO-2:0], in_z_pos[XW-1]};
    xs_r[0] <= in_x_pos;
    for (int i = 1; i < PM; i++) begin
      xs_r[i] <= xs_r[i-1];
    end
    xx_r <= xs_r[0] * xs_r[0];
  end

  // z is only needed for its square and, through zn_r, its sign
  logic signed [XW-1:0] z0_r;
  always_ff @(posedge clk) begin
    z0_r <= in_z_pos;
    zz_r <= z0_r * z0_r;
    ss_r[2] <= $unsigned(xx_r) + $unsigned(zz_r);
    for (int i = 3; i < PM; i++) begin
      ss_r[i] <= ss_r[i-1];
    end
  end

  // digit-by-digit square root, one result bit per stage
  assign srem_r[0] = ss_r[2];
  assign root_r[0] = '0;

  for (genvar g = 0; g < QS; g++) begin : g_sqrt
    localparam logic [SW:0] BIT = (SW + 1)'(1) << (2 * (QS - 1 - g));
    logic [SW:0] trial;
    logic        ge;
    always_comb begin
      trial = root_r[g] + BIT;
      ge    = {1'b0, srem_r[g]} >= trial;
    end
    always_ff @(posedge clk) begin
      srem_r[g+1] <= ge ? (srem_r[g] - trial[SW-1:0]) : srem_r[g];
      root_r[g+1] <= ge ? ((root_r[g] >> 1) + BIT) : (root_r[g] >> 1);
    end
  end

  // products of link lengths and reach
  always_comb begin
    lu  = {upper_r, 4'b0000};
    lf  = {fore_r, 4'b0000};
    lw  = {lower_r, 4'b0000};
    len = root_r[QS][LW-1:0];
  end

  always_ff @(posedge clk) begin
    uu_r  <= lu * lu;
    ff_r  <= lf * lf;
    ww_r  <= lw * lw;
    fw_r  <= lf * lw;
    ul_r  <= lu * len;
    fl_r  <= lf * len;
    len_r <= len;
    xm_r  <= xs_r[PM-1];
    sm_r  <= ss_r[PM-1];
  end

  // numerators and denominators of the three cosines
  always_comb begin
    s_n  = NW'(sm_r);
    uu_n = NW'(uu_r);
    ff_n = NW'(ff_r);
    ww_n = NW'(ww_r);
  end

  always_ff @(posedge clk) begin
    na_r <= NW'(xm_r);
    da_r <= DW'(len_r);
    if (!zn_r[PM]) begin
      nb_r <= $signed(uu_n + s_n - ff_n);
      db_r <= {ul_r, 1'b0};
      nc_r <= $signed(ff_n + s_n - uu_n);
      dc_r <= {fl_r, 1'b0};
    end else begin
      nb_r <= $signed(s_n + ff_n - ww_n);
      db_r <= {fl_r, 1'b0};
      nc_r <= $signed(ff_n + ww_n - s_n);
      dc_r <= DW'({fw_r, 1'b0});
    end
  end

  tlas_cos_lane u_lane_a (.clk(clk), .num(na_r), .den(da_r), .ang(ang_a), .flag(fl_a));
  tlas_cos_lane u_lane_b (.clk(clk), .num(nb_r), .den(db_r), .ang(ang_b), .flag(fl_b));
  tlas_cos_lane u_lane_c (.clk(clk), .num(nc_r), .den(dc_r), .ang(ang_c), .flag(fl_c));

  // angle sums to pulse widths
  always_comb begin
    ea = $signed(KSW'(ang_a));
    eb = $signed(KSW'(ang_b));
    ec = $signed(KSW'(ang_c));
    if (!zn_r[SO-1]) begin
      ka = KSW'(tlas_pkg::QUARTER_TURN) - ea + ec;
      kb = KSW'(tlas_pkg::QUARTER_TURN) - eb - ec;
      kc = KSW'(tlas_pkg::HALF_TURN) - ea - eb;
    end else begin
      ka = ec - KSW'(tlas_pkg::QUARTER_TURN);
      kb = KSW'(tlas_pkg::QUARTER_TURN) + eb - ea;
      kc = '0;
    end
    pa = tlas_pkg::pulse_map(ka);
    pb = tlas_pkg::pulse_map(kb);
    pc = tlas_pkg::pulse_map(kc);
  end

  always_ff @(posedge clk) begin
    out_servo_a_us <= pa[OW-1:0];
    out_servo_b_us <= pb[OW-1:0];
    if (!zn_r[SO-1]) begin
      out_servo_c_us <= pc[OW-1:0];
      out_clamped    <= fl_a || fl_b || fl_c || pa[OW] || pb[OW] || pc[OW];
    end else begin
      out_servo_c_us <= tlas_pkg::PULSE_TOP;
      out_clamped    <= fl_a || fl_b || fl_c || pa[OW] || pb[OW];
    end
  end

  assign out_valid = vld_r[SO];

  `TLAS_ASSERT(a_pulse_range, out_valid |-> (out_servo_a_us >= tlas_pkg::PULSE_BASE) && (out_servo_a_us <= tlas_pkg::PULSE_TOP) && (out_servo_b_us >= tlas_pkg::PULSE_BASE) && (out_servo_b_us <= tlas_pkg::PULSE_TOP), "servo pulse out of range")
  `TLAS_ASSERT(a_below_plane, vld_r[SO-1] && zn_r[SO-1] |=> out_valid && (out_servo_c_us == tlas_pkg::PULSE_TOP), "third servo not held for target below plane")

endmodule
